### design/per_location_linked_list_relink_unit_macros.svh
// Assertion macros for the per-location linked list relink unit.
`ifndef PER_LOCATION_LINKED_LIST_RELINK_UNIT_MACROS_SVH
`define PER_LOCATION_LINKED_LIST_RELINK_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PLLR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pllr_pkg.sv
// Shared constants and payload types of the per-location linked list relink unit.
`default_nettype none

package pllr_pkg;

    localparam int MAX_ITEMS_DEF     = 1024;
    localparam int MAX_LOCATIONS_DEF = 256;

    localparam int PACK_ID_W = 10;
    localparam int LOC_W     = 8;
    localparam int HEAD_W    = 11;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;

    localparam logic MODE_LINK   = 1'b0;
    localparam logic MODE_RELINK = 1'b1;

    typedef struct packed {
        logic [IN_DATA_W-PACK_ID_W-2*LOC_W-1:0] pad;
        logic [LOC_W-1:0]                       new_location;
        logic [LOC_W-1:0]                       old_location;
        logic [PACK_ID_W-1:0]                   pack_id;
    } in_data_t;

    typedef struct packed {
        logic [OUT_DATA_W-2*HEAD_W-2:0] pad;
        logic                           moved;
        logic [HEAD_W-1:0]              old_location_head;
        logic [HEAD_W-1:0]              new_location_head;
    } out_data_t;

endpackage

`default_nettype wire

### design/per_location_linked_list_relink_unit.sv
// Top level: per-location doubly linked lists kept in a head memory and a link memory.
//
//  channel   dir  tdata (low bit up)                               tuser
//  s_*       in   pack_id, old_location, new_location, zero pad    mode
//  m_*       out  new_location_head, old_location_head, moved, pad -
//
//  One item at a time: accept, read steps RD and RD2, then write steps RD2 to WD;
//  the single write port of the link memory takes the four ordered link updates.
//  After reset a clearing pass over max(MAX_ITEMS, MAX_LOCATIONS) addresses (1024 by
//  default) sets every entry to none; s_tready stays low meanwhile.
//  A result waiting in the output register with m_tready low holds the last step.
`default_nettype none

`include "per_location_linked_list_relink_unit_macros.svh"

module per_location_linked_list_relink_unit #(
    parameter int MAX_ITEMS     = pllr_pkg::MAX_ITEMS_DEF,
    parameter int MAX_LOCATIONS = pllr_pkg::MAX_LOCATIONS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // pack_id, old_location, new_location, zero pad
    input  wire logic [pllr_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  wire logic [pllr_pkg::IN_USER_W-1:0]  s_tuser,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // new_location_head, old_location_head, moved, zero pad
    output      logic [pllr_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int LINK_W  = $clog2(MAX_ITEMS + 1);
    localparam int ITEM_AW = $clog2(MAX_ITEMS);
    localparam int LOC_AW  = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int CLR_N   = (MAX_ITEMS > MAX_LOCATIONS) ? MAX_ITEMS : MAX_LOCATIONS;
    localparam int CNT_W   = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    localparam logic [LINK_W-1:0] NONE     = LINK_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(CLR_N - 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_WC   = 3'd5;
    localparam logic [2:0] ST_WD   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg;

    pllr_pkg::in_data_t  op_reg;
    logic                mode_reg;
    logic [LINK_W-1:0]   p_reg, n_reg, oh_reg, h_reg;
    pllr_pkg::out_data_t m_tdata_reg;
    pllr_pkg::out_data_t res;

    logic [LINK_W-1:0]   head_mem [MAX_LOCATIONS];
    logic [2*LINK_W-1:0] link_mem [MAX_ITEMS];
    logic [LINK_W-1:0]   head_rd_reg;
    logic [2*LINK_W-1:0] link_rd_reg;

    logic              head_we;
    logic [LOC_AW-1:0] head_wa, head_ra;
    logic [LINK_W-1:0] head_wd;
    logic              link_we_n, link_we_p;
    logic [ITEM_AW-1:0] link_wa, link_ra;
    logic [LINK_W-1:0] link_wd_n, link_wd_p;

    logic               accept, out_free, out_load;
    logic               item_ok, newl_ok, oldl_ok, mv, relink_mv;
    logic [ITEM_AW-1:0] item_idx;
    logic [LOC_AW-1:0]  newl_idx, oldl_idx;
    logic [LINK_W-1:0]  item_lnk, p_q, n_q, new_head_v, old_head_v;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign item_ok   = 32'(op_reg.pack_id) < MAX_ITEMS;
    assign newl_ok   = 32'(op_reg.new_location) < MAX_LOCATIONS;
    assign oldl_ok   = 32'(op_reg.old_location) < MAX_LOCATIONS;
    assign relink_mv = (mode_reg == pllr_pkg::MODE_RELINK) && item_ok && newl_ok && oldl_ok
                       && (op_reg.old_location != op_reg.new_location);
    assign mv        = relink_mv
                       || ((mode_reg == pllr_pkg::MODE_LINK) && item_ok && newl_ok);

    assign item_idx = ITEM_AW'(op_reg.pack_id);
    assign newl_idx = LOC_AW'(op_reg.new_location);
    assign oldl_idx = LOC_AW'(op_reg.old_location);
    assign item_lnk = LINK_W'(op_reg.pack_id);
    assign p_q      = link_rd_reg[2*LINK_W-1:LINK_W];
    assign n_q      = link_rd_reg[LINK_W-1:0];

    assign new_head_v = mv ? item_lnk : (newl_ok ? h_reg : NONE);
    assign old_head_v = ((mode_reg == pllr_pkg::MODE_LINK) || !oldl_ok) ? NONE :
                        ((mv && (p_reg >= NONE)) ? n_reg : oh_reg);

    always_comb
    begin
        res                   = '0;
        res.new_location_head = pllr_pkg::HEAD_W'(new_head_v);
        res.old_location_head = pllr_pkg::HEAD_W'(old_head_v);
        res.moved             = mv;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        head_we    = 1'b0;
        head_wa    = newl_idx;
        head_wd    = NONE;
        head_ra    = newl_idx;
        link_we_n  = 1'b0;
        link_we_p  = 1'b0;
        link_wa    = item_idx;
        link_wd_n  = NONE;
        link_wd_p  = NONE;
        link_ra    = item_idx;
        case (state_reg)
            ST_CLR:
            begin
                head_we   = 32'(cnt_reg) < MAX_LOCATIONS;
                head_wa   = cnt_reg[LOC_AW-1:0];
                link_we_n = 32'(cnt_reg) < MAX_ITEMS;
                link_we_p = 32'(cnt_reg) < MAX_ITEMS;
                link_wa   = cnt_reg[ITEM_AW-1:0];
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                head_ra    = oldl_idx;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                if (relink_mv)
                begin
                    if (p_q < NONE)
                    begin
                        link_we_n = 1'b1;
                        link_wa   = p_q[ITEM_AW-1:0];
                        link_wd_n = n_q;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wa = oldl_idx;
                        head_wd = n_q;
                    end
                end
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (relink_mv && (n_reg < NONE))
                begin
                    link_we_p = 1'b1;
                    link_wa   = n_reg[ITEM_AW-1:0];
                    link_wd_p = p_reg;
                end
                state_next = ST_WC;
            end
            ST_WC:
            begin
                if (mv)
                begin
                    link_we_n = 1'b1;
                    link_we_p = 1'b1;
                    link_wd_n = h_reg;
                    head_we   = 1'b1;
                    head_wd   = item_lnk;
                end
                state_next = ST_WD;
            end
            ST_WD:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (mv && (h_reg < NONE))
                    begin
                        link_we_p = 1'b1;
                        link_wa   = h_reg[ITEM_AW-1:0];
                        link_wd_p = item_lnk;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd_reg <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (link_we_n)
        begin
            link_mem[link_wa][LINK_W-1:0] <= link_wd_n;
        end
        if (link_we_p)
        begin
            link_mem[link_wa][2*LINK_W-1:LINK_W] <= link_wd_p;
        end
        link_rd_reg <= link_mem[link_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= pllr_pkg::in_data_t'(s_tdata);
            mode_reg <= s_tuser[0];
        end
        if (state_reg == ST_RD2)
        begin
            p_reg  <= p_q;
            n_reg  <= n_q;
            oh_reg <= head_rd_reg;
        end
        if (state_reg == ST_WB)
        begin
            h_reg <= head_rd_reg;
        end
        if (out_load)
        begin
            m_tdata_reg <= res;
        end
    end

    `PLLR_ASSERT_NXT(a_accept_starts_read, accept, state_reg == ST_RD,
        "transfer accepted without starting the read step")
    `PLLR_ASSERT_NOW(a_head_write_needs_move, head_we && (state_reg != ST_CLR), mv,
        "head memory written for an operation that moves nothing")
    `PLLR_ASSERT_NOW(a_link_write_needs_move,
        (link_we_n || link_we_p) && (state_reg != ST_CLR), mv,
        "link memory written for an operation that moves nothing")
    `PLLR_ASSERT_NXT(a_hold_final_step, (state_reg == ST_WD) && m_tvalid && !m_tready,
        state_reg == ST_WD, "final step left while the output register was full")

endmodule

`default_nettype wire
